>>> hw/rtl/iee_pkg.sv
// Shared types and constants for the infix expression evaluator.
package iee_pkg;

  // Fixed widths of the transaction fields.
  localparam int unsigned FIELD_WIDTH        = 32;
  localparam int unsigned KIND_WIDTH         = 3;
  localparam int unsigned DEFAULT_DATA_WIDTH = 32;

  // Operator codes carried in the kind field.
  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_PLUS   = 3'd0,
    KIND_MINUS  = 3'd1,
    KIND_TIMES  = 3'd2,
    KIND_DIVIDE = 3'd3,
    KIND_EQUALS = 3'd4
  } kind_e;

  // Multiplicative operator waiting for its right operand.
  typedef enum logic [1:0] {
    MUL_NONE   = 2'd0,
    MUL_TIMES  = 2'd1,
    MUL_DIVIDE = 2'd2
  } mul_op_e;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_EVAL  = 2'd1,
    ST_WAIT  = 2'd2,
    ST_APPLY = 2'd3
  } state_e;

  // Start request to the serial multiply/divide unit.
  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

endpackage

>>> hw/rtl/iee_in_if.sv
// Input channel: operand and operator with a valid/ready handshake.
interface iee_in_if;
  logic                                         valid;
  logic                                         ready;
  logic signed [iee_pkg::FIELD_WIDTH-1:0]       operand;
  logic        [iee_pkg::KIND_WIDTH-1:0]        kind;

  modport source (output valid, output operand, output kind, input ready);
  modport sink   (input valid, input operand, input kind, output ready);
endinterface

>>> hw/rtl/iee_out_if.sv
// Output channel: expression value and divide-by-zero flag with a valid/ready handshake.
interface iee_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [iee_pkg::FIELD_WIDTH-1:0] value;
  logic                                   divide_by_zero;

  modport source (output valid, output value, output divide_by_zero, input ready);
  modport sink   (input valid, input value, input divide_by_zero, output ready);
endinterface

>>> hw/rtl/iee_muldiv.sv
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
module iee_muldiv #(
  parameter int unsigned DATA_WIDTH = iee_pkg::DEFAULT_DATA_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  iee_pkg::md_req_t      req_i,
  input  logic [DATA_WIDTH-1:0] a_i,
  input  logic [DATA_WIDTH-1:0] b_i,
  output logic                  done_o,
  output logic [DATA_WIDTH-1:0] result_o
);

  localparam int unsigned CntWidth = $clog2(DATA_WIDTH + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic                  div_q, div_d;
  logic                  neg_q, neg_d;
  logic [DATA_WIDTH-1:0] acc_q, acc_d;
  logic [DATA_WIDTH-1:0] sha_q, sha_d;
  logic [DATA_WIDTH-1:0] shb_q, shb_d;

  logic [DATA_WIDTH-1:0] mag_a, mag_b;
  logic [DATA_WIDTH-1:0] rem_shift;
  logic [DATA_WIDTH:0]   diff;
  logic                  qbit;

  // Operand magnitudes for the divider.
  assign mag_a = a_i[DATA_WIDTH-1] ? (~a_i + 1'b1) : a_i;
  assign mag_b = b_i[DATA_WIDTH-1] ? (~b_i + 1'b1) : b_i;

  // Trial subtraction of one restoring-division step.
  assign rem_shift = {acc_q[DATA_WIDTH-2:0], sha_q[DATA_WIDTH-1]};
  assign diff      = {1'b0, rem_shift} - {1'b0, shb_q};
  assign qbit      = ~diff[DATA_WIDTH];

  // One multiplier or quotient bit per cycle.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    div_d  = div_q;
    neg_d  = neg_q;
    acc_d  = acc_q;
    sha_d  = sha_q;
    shb_d  = shb_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CntWidth'(DATA_WIDTH);
      div_d  = req_i.is_div;
      neg_d  = a_i[DATA_WIDTH-1] ^ b_i[DATA_WIDTH-1];
      acc_d  = '0;
      sha_d  = req_i.is_div ? mag_a : a_i;
      shb_d  = req_i.is_div ? mag_b : b_i;
    end else if (busy_q) begin
      if (div_q) begin
        acc_d = qbit ? diff[DATA_WIDTH-1:0] : rem_shift;
        sha_d = {sha_q[DATA_WIDTH-2:0], qbit};
      end else begin
        if (shb_q[0]) begin
          acc_d = acc_q + sha_q;
        end
        sha_d = {sha_q[DATA_WIDTH-2:0], 1'b0};
        shb_d = {1'b0, shb_q[DATA_WIDTH-1:1]};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntWidth'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    neg_q <= neg_d;
    acc_q <= acc_d;
    sha_q <= sha_d;
    shb_q <= shb_d;
  end

  // The quotient ends up in the dividend shift register.
  assign done_o   = done_q;
  assign result_o = div_q ? (neg_q ? (~sha_q + 1'b1) : sha_q) : acc_q;

endmodule

>>> hw/rtl/infix_expression_evaluator.sv
// Top level of the two-level precedence infix expression evaluator.
// Each input transaction carries an operand and the operator that follows it; a result
// transaction leaves only on equals, with the wrapped value and a flag that tells whether
// any division had a zero divisor. A token that meets a pending times, or a pending divide
// by a nonzero operand, keeps the input not ready while the shared serial unit works on
// it, because the multiply and divide run there one bit per cycle; a token with operator
// code 5 to 7 is ignored. A finished result waits in an output register, so the block
// keeps taking tokens until a second equals finds it still full and holds there until it
// drains.
module infix_expression_evaluator #(
  parameter int unsigned DATA_WIDTH = iee_pkg::DEFAULT_DATA_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  iee_in_if.sink     in_i,
  iee_out_if.source  out_o
);

  localparam int unsigned FW = iee_pkg::FIELD_WIDTH;

  iee_pkg::state_e                   state_q, state_d;
  iee_pkg::mul_op_e                  mul_op_q, mul_op_d;
  logic                              neg_q, neg_d;
  logic                              err_q, err_d;
  logic                              out_valid_q, out_valid_d;
  logic [DATA_WIDTH-1:0]             sum_q, sum_d;
  logic [DATA_WIDTH-1:0]             prod_q, prod_d;
  logic [DATA_WIDTH-1:0]             term_q, term_d;
  logic [DATA_WIDTH-1:0]             opnd_q, opnd_d;
  logic [iee_pkg::KIND_WIDTH-1:0]    kind_q, kind_d;
  logic [FW-1:0]                     value_q, value_d;
  logic                              dz_q, dz_d;

  logic [DATA_WIDTH-1:0]             opnd_ext;
  logic [DATA_WIDTH-1:0]             fold;
  logic [FW-1:0]                     fold_out;
  logic                              in_fire;
  logic                              out_free;
  iee_pkg::md_req_t                  md_req;
  logic                              md_done;
  logic [DATA_WIDTH-1:0]             md_result;

  // Resize between the field width and the working width.
  if (DATA_WIDTH > FW) begin : g_wide
    assign opnd_ext = {{(DATA_WIDTH - FW){in_i.operand[FW-1]}}, in_i.operand};
    assign fold_out = fold[FW-1:0];
  end else if (DATA_WIDTH == FW) begin : g_same
    assign opnd_ext = in_i.operand;
    assign fold_out = fold;
  end else begin : g_narrow
    assign opnd_ext = in_i.operand[DATA_WIDTH-1:0];
    assign fold_out = {{(FW - DATA_WIDTH){1'b0}}, fold};
  end

  assign in_i.ready = (state_q == iee_pkg::ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Add or subtract the finished term into the running sum.
  assign fold = neg_q ? (sum_q - term_q) : (sum_q + term_q);

  iee_muldiv #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (md_req),
    .a_i     (prod_q),
    .b_i     (opnd_q),
    .done_o  (md_done),
    .result_o(md_result)
  );

  // Sequencer: evaluate the pending operator, then apply the new one.
  always_comb begin
    state_d     = state_q;
    mul_op_d    = mul_op_q;
    neg_d       = neg_q;
    err_d       = err_q;
    sum_d       = sum_q;
    prod_d      = prod_q;
    term_d      = term_q;
    opnd_d      = opnd_q;
    kind_d      = kind_q;
    value_d     = value_q;
    dz_d        = dz_q;
    out_valid_d = out_valid_q && !out_o.ready;
    md_req      = '0;

    unique case (state_q)
      iee_pkg::ST_IDLE: begin
        if (in_fire) begin
          opnd_d  = opnd_ext;
          kind_d  = in_i.kind;
          state_d = iee_pkg::ST_EVAL;
        end
      end
      iee_pkg::ST_EVAL: begin
        if (kind_q > iee_pkg::KIND_EQUALS) begin
          state_d = iee_pkg::ST_IDLE;
        end else begin
          case (mul_op_q)
            iee_pkg::MUL_TIMES: begin
              md_req.start = 1'b1;
              state_d      = iee_pkg::ST_WAIT;
            end
            iee_pkg::MUL_DIVIDE: begin
              if (opnd_q == '0) begin
                // Zero divisor: keep the term and remember the error.
                err_d   = 1'b1;
                term_d  = prod_q;
                state_d = iee_pkg::ST_APPLY;
              end else begin
                md_req.start  = 1'b1;
                md_req.is_div = 1'b1;
                state_d       = iee_pkg::ST_WAIT;
              end
            end
            default: begin
              term_d  = opnd_q;
              state_d = iee_pkg::ST_APPLY;
            end
          endcase
        end
      end
      iee_pkg::ST_WAIT: begin
        if (md_done) begin
          term_d  = md_result;
          state_d = iee_pkg::ST_APPLY;
        end
      end
      iee_pkg::ST_APPLY: begin
        case (kind_q)
          iee_pkg::KIND_TIMES, iee_pkg::KIND_DIVIDE: begin
            prod_d   = term_q;
            mul_op_d = (kind_q == iee_pkg::KIND_TIMES) ? iee_pkg::MUL_TIMES
                                                       : iee_pkg::MUL_DIVIDE;
            state_d  = iee_pkg::ST_IDLE;
          end
          iee_pkg::KIND_EQUALS: begin
            // Hold until the output register can take the result.
            if (out_free) begin
              value_d     = fold_out;
              dz_d        = err_q;
              out_valid_d = 1'b1;
              sum_d       = '0;
              prod_d      = '0;
              mul_op_d    = iee_pkg::MUL_NONE;
              neg_d       = 1'b0;
              err_d       = 1'b0;
              state_d     = iee_pkg::ST_IDLE;
            end
          end
          default: begin
            sum_d    = fold;
            prod_d   = '0;
            mul_op_d = iee_pkg::MUL_NONE;
            neg_d    = (kind_q == iee_pkg::KIND_MINUS);
            state_d  = iee_pkg::ST_IDLE;
          end
        endcase
      end
      default: begin
        state_d = iee_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and expression state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iee_pkg::ST_IDLE;
      mul_op_q    <= iee_pkg::MUL_NONE;
      neg_q       <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
      prod_q      <= '0;
    end else begin
      state_q     <= state_d;
      mul_op_q    <= mul_op_d;
      neg_q       <= neg_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
      prod_q      <= prod_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    term_q  <= term_d;
    opnd_q  <= opnd_d;
    kind_q  <= kind_d;
    value_q <= value_d;
    dz_q    <= dz_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.value          = value_q;
  assign out_o.divide_by_zero = dz_q;

  // The serial unit only finishes while the sequencer waits for it.
  a_md_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_done |-> (state_q == iee_pkg::ST_WAIT))
    else $error("Serial unit finished outside the wait state.");

  // A new result is only loaded from the apply step.
  a_out_from_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == iee_pkg::ST_APPLY))
    else $error("Output became valid without an equals transaction.");

  // With no pending multiplicative operator the product term is clear.
  a_prod_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mul_op_q == iee_pkg::MUL_NONE) |-> (prod_q == '0))
    else $error("Product term nonzero with no pending operator.");

endmodule

>>> sim/iee_checker.sv
// Checker for the infix expression evaluator: predicts each expression value and compares results.
`timescale 1ns / 1ps

module iee_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  iee_in_if           in_mon,
  iee_out_if          out_mon,
  input  logic        end_of_run_i,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);
  import iee_pkg::*;

  localparam int unsigned W = FIELD_WIDTH;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [W-1:0] value;
    logic         divide_by_zero;
  } expr_result_t;

  // Shadow copy of the evaluator state.
  logic [W-1:0] sum_acc;
  logic [W-1:0] term_acc;
  mul_op_e      mul_pending;
  logic         negate_pending;
  logic         div_zero_seen;

  expr_result_t expected_results_q[$];
  int unsigned  mismatch_cnt;

  // Quotient truncated toward zero, computed on magnitudes so that the most
  // negative value over minus one wraps back to the most negative value.
  function automatic logic [W-1:0] trunc_quotient(logic [W-1:0] num, logic [W-1:0] den);
    logic [W-1:0] num_mag;
    logic [W-1:0] den_mag;
    logic [W-1:0] quo;
    num_mag = num[W-1] ? -num : num;
    den_mag = den[W-1] ? -den : den;
    quo = num_mag / den_mag;
    return (num[W-1] ^ den[W-1]) ? -quo : quo;
  endfunction

  task automatic flag_error(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_LIMIT) begin
      $display("[%0t] checker: %s", $time, msg);
    end
  endtask

  // Result transactions are compared before the input side is processed, so
  // a result never meets an expectation pushed at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    logic [W-1:0] opnd;
    logic [W-1:0] term;
    expr_result_t got;
    expr_result_t want;
    if (!rst_ni) begin
      sum_acc        = '0;
      term_acc       = '0;
      mul_pending    = MUL_NONE;
      negate_pending = 1'b0;
      div_zero_seen  = 1'b0;
      expected_results_q.delete();
      mismatch_cnt   = 0;
      outstanding_o  = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.value          = out_mon.value;
        got.divide_by_zero = out_mon.divide_by_zero;
        if (expected_results_q.size() == 0) begin
          flag_error($sformatf("unexpected result value %0d divide_by_zero %0b",
                               $signed(got.value), got.divide_by_zero));
        end else begin
          want = expected_results_q.pop_front();
          if (got.value !== want.value) begin
            flag_error($sformatf("value expected %0d got %0d",
                                 $signed(want.value), $signed(got.value)));
          end
          if (got.divide_by_zero !== want.divide_by_zero) begin
            flag_error($sformatf("divide_by_zero expected %0b got %0b",
                                 want.divide_by_zero, got.divide_by_zero));
          end
        end
      end

      // Operator codes above equals leave the state alone.
      if (in_mon.valid && in_mon.ready && in_mon.kind <= KIND_EQUALS) begin
        opnd = in_mon.operand;
        case (mul_pending)
          MUL_TIMES: begin
            term = term_acc * opnd;
          end
          MUL_DIVIDE: begin
            if (opnd == '0) begin
              // A zero divisor skips the division and is reported on equals.
              div_zero_seen = 1'b1;
              term = term_acc;
            end else begin
              term = trunc_quotient(term_acc, opnd);
            end
          end
          default: begin
            term = opnd;
          end
        endcase

        if (in_mon.kind == KIND_TIMES || in_mon.kind == KIND_DIVIDE) begin
          term_acc    = term;
          mul_pending = (in_mon.kind == KIND_TIMES) ? MUL_TIMES : MUL_DIVIDE;
        end else begin
          sum_acc     = negate_pending ? sum_acc - term : sum_acc + term;
          term_acc    = '0;
          mul_pending = MUL_NONE;
          if (in_mon.kind == KIND_EQUALS) begin
            want.value          = sum_acc;
            want.divide_by_zero = div_zero_seen;
            expected_results_q.push_back(want);
            sum_acc        = '0;
            negate_pending = 1'b0;
            div_zero_seen  = 1'b0;
          end else begin
            negate_pending = (in_mon.kind == KIND_MINUS);
          end
        end
      end
      outstanding_o = expected_results_q.size();
    end
  end

  // Expectations still waiting at the end of the run count as failures.
  assign fail_count_o = mismatch_cnt + (end_of_run_i ? outstanding_o : 0);

  always @(posedge end_of_run_i) begin
    if (outstanding_o != 0) begin
      $display("[%0t] checker: %0d expected results never arrived", $time, outstanding_o);
    end
  end

endmodule

>>> sim/infix_expression_evaluator_tb.sv
// Testbench top for the infix expression evaluator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module infix_expression_evaluator_tb;
  import iee_pkg::*;

  localparam int unsigned W              = FIELD_WIDTH;
  localparam int unsigned RANDOM_ITEMS   = 900;
  localparam int unsigned STALL_PERCENT  = 70;
  localparam int unsigned LIGHT_PERCENT  = 9;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = DEFAULT_DATA_WIDTH + 8;
  localparam int unsigned NOISE_KIND_MAX = (1 << KIND_WIDTH) - 1;
  localparam logic [W-1:0] VAL_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VAL_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] VAL_NEG_ONE = '1;

  // Idling pattern of the two channels.
  typedef enum int {
    TRAFFIC_FREE,
    TRAFFIC_SEND_GAPS,
    TRAFFIC_RECV_STALLS,
    TRAFFIC_BOTH
  } traffic_e;

  typedef struct {
    logic [W-1:0]          operand;
    logic [KIND_WIDTH-1:0] kind;
  } token_t;

  logic        clk_i;
  logic        rst_ni;
  logic        end_of_run;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned quiet_cycles;
  traffic_e    traffic;

  iee_in_if  in_ch ();
  iee_out_if out_ch ();

  infix_expression_evaluator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  iee_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .end_of_run_i  (end_of_run),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit stall_now(bit sender);
    case (traffic)
      TRAFFIC_SEND_GAPS:   return sender && ($urandom_range(0, 99) < STALL_PERCENT);
      TRAFFIC_RECV_STALLS: return !sender && ($urandom_range(0, 99) < STALL_PERCENT);
      TRAFFIC_BOTH:        return $urandom_range(0, 99) < LIGHT_PERCENT;
      default:             return 1'b0;
    endcase
  endfunction

  // Operands lean toward zero, small values and the extremes, with plenty of
  // fully random words so that every bit toggles.
  function automatic logic [W-1:0] rand_operand();
    int small_v;
    case ($urandom_range(0, 9))
      0: return '0;
      1: begin
        case ($urandom_range(0, 3))
          0:       return VAL_MAX;
          1:       return VAL_MIN;
          2:       return VAL_NEG_ONE;
          default: return W'(1);
        endcase
      end
      2, 3, 4, 5: begin
        small_v = $urandom_range(0, 40);
        return W'(small_v - 20);
      end
      default: return W'($urandom);
    endcase
  endfunction

  // Drives one transaction and returns after the edge that accepts it.
  task automatic push_token(token_t tok);
    @(negedge clk_i);
    while (stall_now(1'b1)) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid   = 1'b1;
    in_ch.operand = tok.operand;
    in_ch.kind    = tok.kind;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Receiver side: ready is redrawn at every falling edge.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready = !stall_now(1'b0);
    end
  end

  // Watchdog on cycles in which no transaction moves on either channel.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d idle cycles", quiet_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    token_t      directed_q[$];
    token_t      random_q[$];
    token_t      tok;
    traffic_e    schedule[8];
    int unsigned counted;
    int unsigned n_terms;
    int unsigned seg_len;
    int unsigned idx;

    in_ch.valid   = 1'b0;
    in_ch.operand = '0;
    in_ch.kind    = KIND_PLUS;
    end_of_run    = 1'b0;
    quiet_cycles  = 0;
    traffic       = TRAFFIC_FREE;
    rst_ni        = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed expressions: simple sum, wrapping product, most negative over
    // minus one, zero divisor, truncation toward zero, mixed precedence,
    // ignored operator codes, wrapping sums and chained divides by zero.
    directed_q = '{
      '{W'(1), KIND_PLUS},       '{W'(2), KIND_EQUALS},
      '{VAL_MAX, KIND_TIMES},    '{W'(2), KIND_EQUALS},
      '{VAL_MIN, KIND_DIVIDE},   '{VAL_NEG_ONE, KIND_EQUALS},
      '{W'(7), KIND_DIVIDE},     '{W'(0), KIND_MINUS},       '{W'(3), KIND_EQUALS},
      '{W'(-7), KIND_DIVIDE},    '{W'(2), KIND_EQUALS},
      '{W'(10), KIND_MINUS},     '{W'(-3), KIND_TIMES},      '{W'(2), KIND_DIVIDE},
      '{W'(-4), KIND_EQUALS},
      '{W'(5), KIND_EQUALS + 3'd1}, '{W'(9), KIND_EQUALS + 3'd2},
      '{VAL_NEG_ONE, KIND_EQUALS + 3'd3}, '{W'(3), KIND_EQUALS},
      '{VAL_MIN, KIND_MINUS},    '{W'(1), KIND_EQUALS},
      '{W'(0), KIND_EQUALS},
      '{VAL_NEG_ONE, KIND_TIMES}, '{VAL_NEG_ONE, KIND_PLUS}, '{VAL_MAX, KIND_EQUALS},
      '{W'(0), KIND_DIVIDE},     '{W'(0), KIND_DIVIDE},      '{W'(5), KIND_EQUALS},
      '{VAL_MAX, KIND_PLUS},     '{VAL_MAX, KIND_EQUALS}
    };
    foreach (directed_q[i]) push_token(directed_q[i]);

    // Random expressions, mostly short, some long chains, with the odd
    // transaction carrying an unused operator code.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      n_terms = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 6);
      for (int t = 0; t < n_terms; t++) begin
        if ($urandom_range(0, 19) == 0) begin
          tok.operand = W'($urandom);
          tok.kind    = KIND_WIDTH'($urandom_range(KIND_EQUALS + 1, NOISE_KIND_MAX));
          random_q.push_back(tok);
        end
        tok.operand = rand_operand();
        if (t == n_terms - 1) begin
          tok.kind = KIND_EQUALS;
        end else begin
          tok.kind = KIND_WIDTH'($urandom_range(KIND_PLUS, KIND_DIVIDE));
        end
        random_q.push_back(tok);
        counted++;
      end
    end

    // Walk the random stream through every idling pattern, twice over.
    schedule = '{TRAFFIC_FREE, TRAFFIC_SEND_GAPS, TRAFFIC_RECV_STALLS, TRAFFIC_BOTH,
                 TRAFFIC_FREE, TRAFFIC_BOTH, TRAFFIC_SEND_GAPS, TRAFFIC_RECV_STALLS};
    seg_len = (random_q.size() + 7) / 8;
    idx = 0;
    foreach (random_q[i]) begin
      if (i % seg_len == 0) begin
        traffic = schedule[idx];
        idx++;
      end
      push_token(random_q[i]);
    end

    @(negedge clk_i);
    in_ch.valid = 1'b0;
    traffic     = TRAFFIC_FREE;

    // Drain the outstanding results, then give the block time to go quiet.
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    end_of_run = 1'b1;
    @(posedge clk_i);

    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/iee_pkg.sv
hw/rtl/iee_in_if.sv
hw/rtl/iee_out_if.sv
hw/rtl/iee_muldiv.sv
hw/rtl/infix_expression_evaluator.sv
sim/iee_checker.sv
sim/infix_expression_evaluator_tb.sv
